@@ rtl/core/tps_pkg.sv @@
`timescale 1ns / 1ps

package tps_pkg;

    localparam int MAX_FRAGMENTS = 6;
    localparam int IDX_W         = $clog2(MAX_FRAGMENTS);
    localparam int CNT_W         = $clog2(MAX_FRAGMENTS + 1);

    localparam int FUNC_W    = 2;
    localparam int CODE_W    = 2;
    localparam int FREQ_W    = 16;
    localparam int TICKS_W   = 16;
    localparam int PERIOD_W  = 20;
    localparam int COMPARE_W = 19;
    localparam int BIT_W     = $clog2(PERIOD_W);

    localparam logic [PERIOD_W-1:0] CLOCK_HZ  = 20'd1000000;
    localparam logic [FREQ_W-1:0]   LOCK_FREQ = 16'd3000;

    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRIGGER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BEEP    = 2'd2;

    localparam logic [CODE_W-1:0] STATUS_INIT_OK  = 2'd0;
    localparam logic [CODE_W-1:0] STATUS_CLICK   = 2'd1;
    localparam logic [CODE_W-1:0] STATUS_WARN    = 2'd2;
    localparam logic [CODE_W-1:0] STATUS_CRITICAL = 2'd3;

    typedef struct packed {
        logic [FREQ_W-1:0]  freq;
        logic [TICKS_W-1:0] ticks;
    } fragment_t;

    function automatic fragment_t rom_fragment(input logic [CODE_W-1:0] code,
                                               input logic [IDX_W-1:0] idx);
        fragment_t frag;
        frag = '{freq: '0, ticks: '0};
        unique case (code)
            STATUS_INIT_OK:
            begin
                case (idx)
                    IDX_W'(0): frag = '{freq: 16'd1500, ticks: 16'd80};
                    IDX_W'(1): frag = '{freq: 16'd0,    ticks: 16'd30};
                    IDX_W'(2): frag = '{freq: 16'd2500, ticks: 16'd120};
                    default:   frag = '{freq: '0, ticks: '0};
                endcase
            end
            STATUS_CLICK:
            begin
                case (idx)
                    IDX_W'(0): frag = '{freq: 16'd2500, ticks: 16'd120};
                    IDX_W'(1): frag = '{freq: 16'd0,    ticks: 16'd20};
                    IDX_W'(2): frag = '{freq: 16'd3000, ticks: 16'd180};
                    default:   frag = '{freq: '0, ticks: '0};
                endcase
            end
            STATUS_WARN:
            begin
                case (idx)
                    IDX_W'(0): frag = '{freq: 16'd1500, ticks: 16'd200};
                    IDX_W'(1): frag = '{freq: 16'd0,    ticks: 16'd50};
                    IDX_W'(2): frag = '{freq: 16'd1500, ticks: 16'd200};
                    default:   frag = '{freq: '0, ticks: '0};
                endcase
            end
            STATUS_CRITICAL:
            begin
                case (idx)
                    IDX_W'(0): frag = '{freq: 16'd3000, ticks: 16'd80};
                    IDX_W'(1): frag = '{freq: 16'd0,    ticks: 16'd50};
                    IDX_W'(2): frag = '{freq: 16'd3000, ticks: 16'd80};
                    IDX_W'(3): frag = '{freq: 16'd0,    ticks: 16'd50};
                    IDX_W'(4): frag = '{freq: 16'd3000, ticks: 16'd80};
                    IDX_W'(5): frag = '{freq: 16'd0,    ticks: 16'd50};
                    default:   frag = '{freq: '0, ticks: '0};
                endcase
            end
        endcase
        return frag;
    endfunction

    function automatic logic [CNT_W-1:0] rom_len(input logic [CODE_W-1:0] code);
        logic [CNT_W-1:0] len;
        if (code == STATUS_CRITICAL)
        begin
            len = CNT_W'(6);
        end
        else
        begin
            len = CNT_W'(3);
        end
        return len;
    endfunction

endpackage

@@ rtl/core/tps_in_if.sv @@
`timescale 1ns / 1ps

interface tps_in_if;
    logic                          valid;
    logic                          ready;
    logic [tps_pkg::FUNC_W-1:0]    func;
    logic [tps_pkg::CODE_W-1:0]    status_code;
    logic [tps_pkg::FREQ_W-1:0]    beep_frequency;
    logic [tps_pkg::TICKS_W-1:0]   beep_duration;

    modport source (output valid, func, status_code, beep_frequency, beep_duration,
                    input ready);
    modport sink   (input valid, func, status_code, beep_frequency, beep_duration,
                    output ready);
endinterface

@@ rtl/core/tps_out_if.sv @@
`timescale 1ns / 1ps

interface tps_out_if;
    logic                             valid;
    logic                             ready;
    logic [tps_pkg::PERIOD_W-1:0]     period_count;
    logic [tps_pkg::COMPARE_W-1:0]    compare_count;
    logic                             busy_res;
    logic                             sound_on;

    modport source (output valid, period_count, compare_count, busy_res, sound_on,
                    input ready);
    modport sink   (input valid, period_count, compare_count, busy_res, sound_on,
                    output ready);
endinterface

@@ rtl/core/tone_pattern_sequencer_core.sv @@
`timescale 1ns / 1ps
// A tick that loads no tone, or an ignored request, goes straight to the output; a tick that
// loads a fragment first reads it from memory, a trigger or beep first writes its fragments (a
// beep its two). A silent tone then goes to the output; a tone runs 20 divider steps for the
// PWM period, forms period and compare, then registers the output. One transaction in work at
// a time; ready again once its result is registered; a result not yet taken holds back the next one.
// Reset clears all control state and the PWM registers; the fragment memory is not cleared.

module tone_pattern_sequencer_core
(
    input  logic         clk,
    input  logic         rst_n,
    tps_in_if.sink       cmd,
    tps_out_if.source    res
);
    import tps_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Fragment store, one entry per fragment.
    fragment_t frag_mem [MAX_FRAGMENTS];
    fragment_t rdata_reg;

    logic [2:0]             state_reg, state_next;
    logic                   playing_reg, playing_next;
    logic                   lock_reg, lock_next;
    logic [TICKS_W-1:0]     remain_reg, remain_next;
    logic [CNT_W-1:0]       index_reg, index_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [COMPARE_W-1:0]   compare_reg, compare_next;
    logic [CNT_W-1:0]       wr_cnt_reg, wr_cnt_next;
    logic [CNT_W-1:0]       wr_len_reg, wr_len_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   beep_sel_reg, beep_sel_next;
    logic [CODE_W-1:0]      code_reg, code_next;
    logic [FREQ_W-1:0]      freq_reg, freq_next;
    logic [TICKS_W-1:0]     dur_reg, dur_next;
    logic [FREQ_W-1:0]      div_reg, div_next;
    logic [FREQ_W-1:0]      rem_reg, rem_next;
    logic [PERIOD_W-1:0]    quo_reg, quo_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;

    logic [PERIOD_W-1:0]    out_period_reg;
    logic [COMPARE_W-1:0]   out_compare_reg;
    logic                   out_busy_reg;
    logic                   out_sound_reg;

    logic                   wr_en;
    fragment_t              wr_data;
    fragment_t              first_frag;
    logic                   tone_go;
    logic [FREQ_W-1:0]      tone_freq;
    logic [FREQ_W:0]        trial;
    logic                   trial_ge;
    logic [CNT_W-1:0]       index_inc;
    logic                   out_load;

    assign cmd.ready = (state_reg == ST_IDLE);

    assign res.valid         = out_valid_reg;
    assign res.period_count  = out_period_reg;
    assign res.compare_count = out_compare_reg;
    assign res.busy_res      = out_busy_reg;
    assign res.sound_on      = out_sound_reg;

    assign index_inc = index_reg + CNT_W'(1);
    assign trial     = {rem_reg, CLOCK_HZ[bit_reg]};
    assign trial_ge  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        if (beep_sel_reg)
        begin
            first_frag = '{freq: freq_reg, ticks: dur_reg};
            if (wr_cnt_reg == '0)
            begin
                wr_data = '{freq: freq_reg, ticks: dur_reg};
            end
            else
            begin
                wr_data = '{freq: '0, ticks: TICKS_W'(1)};
            end
        end
        else
        begin
            first_frag = rom_fragment(code_reg, '0);
            wr_data    = rom_fragment(code_reg, wr_cnt_reg[IDX_W-1:0]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        playing_next   = playing_reg;
        lock_next      = lock_reg;
        remain_next    = remain_reg;
        index_next     = index_reg;
        total_next     = total_reg;
        period_next    = period_reg;
        compare_next   = compare_reg;
        wr_cnt_next    = wr_cnt_reg;
        wr_len_next    = wr_len_reg;
        beep_sel_next  = beep_sel_reg;
        code_next      = code_reg;
        freq_next      = freq_reg;
        dur_next       = dur_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        bit_next       = bit_reg;
        wr_en          = 1'b0;
        tone_go        = 1'b0;
        tone_freq      = '0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_DONE;
                    code_next  = cmd.status_code;
                    freq_next  = cmd.beep_frequency;
                    dur_next   = cmd.beep_duration;
                    wr_cnt_next = '0;
                    priority if (cmd.func == FUNC_TICK)
                    begin
                        if (playing_reg)
                        begin
                            if (remain_reg != '0)
                            begin
                                remain_next = remain_reg - TICKS_W'(1);
                            end
                            else
                            begin
                                index_next = index_inc;
                                if (index_inc < total_reg
                                    && index_inc < CNT_W'(MAX_FRAGMENTS))
                                begin
                                    state_next = ST_READ;
                                end
                                else
                                begin
                                    compare_next = '0;
                                    playing_next = 1'b0;
                                end
                            end
                        end
                    end
                    else if (cmd.func == FUNC_TRIGGER)
                    begin
                        // A locked pattern (first tone at LOCK_FREQ) still playing only yields to a critical trigger.
                        if (!(playing_reg && lock_reg && cmd.status_code != STATUS_CRITICAL))
                        begin
                            beep_sel_next = 1'b0;
                            wr_len_next   = rom_len(cmd.status_code);
                            state_next    = ST_WRITE;
                        end
                    end
                    else if (cmd.func == FUNC_BEEP)
                    begin
                        if (cmd.beep_duration != '0)
                        begin
                            beep_sel_next = 1'b1;
                            wr_len_next   = CNT_W'(2);
                            state_next    = ST_WRITE;
                        end
                    end
                    else
                    begin
                        // The unused function code only reports the current state.
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WRITE:
            begin
                wr_en = 1'b1;
                if (wr_cnt_reg == wr_len_reg - CNT_W'(1))
                begin
                    index_next   = '0;
                    total_next   = wr_len_reg;
                    playing_next = 1'b1;
                    lock_next    = (first_frag.freq == LOCK_FREQ);
                    remain_next  = first_frag.ticks;
                    tone_go      = 1'b1;
                    tone_freq    = first_frag.freq;
                end
                else
                begin
                    wr_cnt_next = wr_cnt_reg + CNT_W'(1);
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (rdata_reg.ticks == '0)
                begin
                    remain_next = TICKS_W'(1);
                end
                else
                begin
                    remain_next = rdata_reg.ticks;
                end
                tone_go   = 1'b1;
                tone_freq = rdata_reg.freq;
            end
            ST_DIV:
            begin
                if (trial_ge)
                begin
                    rem_next = FREQ_W'(trial - {1'b0, div_reg});
                end
                else
                begin
                    rem_next = trial[FREQ_W-1:0];
                end
                quo_next = {quo_reg[PERIOD_W-2:0], trial_ge};
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                period_next  = quo_reg - PERIOD_W'(1);
                compare_next = quo_reg[PERIOD_W-1:1];
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (tone_go)
        begin
            if (tone_freq == '0)
            begin
                compare_next = '0;
                state_next   = ST_DONE;
            end
            else
            begin
                div_next   = tone_freq;
                rem_next   = '0;
                quo_next   = '0;
                bit_next   = BIT_W'(PERIOD_W - 1);
                state_next = ST_DIV;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frag_mem[wr_cnt_reg[IDX_W-1:0]] <= wr_data;
        end
        if (state_reg == ST_READ)
        begin
            rdata_reg <= frag_mem[index_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            playing_reg   <= 1'b0;
            lock_reg      <= 1'b0;
            remain_reg    <= '0;
            index_reg     <= '0;
            total_reg     <= '0;
            period_reg    <= '0;
            compare_reg   <= '0;
            wr_cnt_reg    <= '0;
            wr_len_reg    <= '0;
            beep_sel_reg  <= 1'b0;
            code_reg      <= STATUS_INIT_OK;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            playing_reg   <= playing_next;
            lock_reg      <= lock_next;
            remain_reg    <= remain_next;
            index_reg     <= index_next;
            total_reg     <= total_next;
            period_reg    <= period_next;
            compare_reg   <= compare_next;
            wr_cnt_reg    <= wr_cnt_next;
            wr_len_reg    <= wr_len_next;
            beep_sel_reg  <= beep_sel_next;
            code_reg      <= code_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg <= freq_next;
        dur_reg  <= dur_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        if (out_load)
        begin
            out_period_reg  <= period_reg;
            out_compare_reg <= compare_reg;
            out_busy_reg    <= playing_reg;
            out_sound_reg   <= (compare_reg != '0);
        end
    end

endmodule
